>>> rtl/core/lobm_pkg.sv
// lobm_pkg: shared types and codes of the limit order book matcher
// no dependencies; used by lobm_cell, limit_order_book_matcher and the testbench

package lobm_pkg;

  localparam int unsigned IdBits      = 32;
  localparam int unsigned ArrivalBits = 32;
  localparam int unsigned KindBits    = 3;
  // cells between two registers of the best bid/ask scan chain
  localparam int unsigned ScanSegCells = 8;

  typedef enum logic [KindBits-1:0] {
    RES_TRADE     = 3'd0,
    RES_ADD_DONE  = 3'd1,
    RES_ADD_FULL  = 3'd2,
    RES_CANCELLED = 3'd3,
    RES_NOT_FOUND = 3'd4
  } res_kind_e;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_CANCEL = 1'b1;
  localparam logic SIDE_BUY    = 1'b0;
  localparam logic SIDE_SELL   = 1'b1;

  // per cell commands, broadcast to the whole row
  typedef struct packed {
    logic                 write;    // write the new order into the selected cell
    logic                 cancel;   // drop every valid cell with matching id
    logic                 trade;    // subtract trade quantity from the two selected cells
  } cell_cmd_t;

endpackage

>>> rtl/core/lobm_cell.sv
// lobm_cell: one slot of the order book plus one stage of the best bid/ask scan chain
// depends on lobm_pkg

module lobm_cell #(
  parameter int unsigned PriceBits = 16,
  parameter int unsigned QtyBits   = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  lobm_pkg::cell_cmd_t             cmd_i,
  input  logic                            sel_wr_i,
  input  logic                            sel_bid_i,
  input  logic                            sel_ask_i,
  input  logic [lobm_pkg::IdBits-1:0]     new_id_i,
  input  logic                            new_side_i,
  input  logic [PriceBits-1:0]            new_price_i,
  input  logic [QtyBits-1:0]              new_qty_i,
  input  logic [lobm_pkg::ArrivalBits-1:0] new_arrival_i,
  input  logic [QtyBits-1:0]              trade_qty_i,
  input  logic [lobm_pkg::ArrivalBits-1:0] counter_i,
  // scan chain in from the previous cell
  input  logic                            bid_v_i,
  input  logic [PriceBits-1:0]            bid_p_i,
  input  logic [lobm_pkg::ArrivalBits-1:0] bid_age_i,
  input  logic                            ask_v_i,
  input  logic [PriceBits-1:0]            ask_p_i,
  input  logic [lobm_pkg::ArrivalBits-1:0] ask_age_i,
  output logic                            bid_v_o,
  output logic [PriceBits-1:0]            bid_p_o,
  output logic [lobm_pkg::ArrivalBits-1:0] bid_age_o,
  output logic                            bid_win_o,
  output logic                            ask_v_o,
  output logic [PriceBits-1:0]            ask_p_o,
  output logic [lobm_pkg::ArrivalBits-1:0] ask_age_o,
  output logic                            ask_win_o,
  output logic                            valid_o,
  output logic                            id_hit_o,
  output logic [lobm_pkg::IdBits-1:0]     id_o,
  output logic [PriceBits-1:0]            price_o,
  output logic [QtyBits-1:0]              rem_o
);

  logic                             valid_q, valid_d;
  logic [lobm_pkg::IdBits-1:0]      id_q;
  logic                             side_q;
  logic [PriceBits-1:0]             price_q;
  logic [QtyBits-1:0]               rem_q, rem_d;
  logic [lobm_pkg::ArrivalBits-1:0] arr_q;
  logic [lobm_pkg::ArrivalBits-1:0] age;
  logic                             sel_tr;

  assign age      = counter_i - arr_q;
  assign id_hit_o = valid_q && (id_q == new_id_i);
  assign valid_o  = valid_q;
  assign id_o     = id_q;
  assign price_o  = price_q;
  assign rem_o    = rem_q;
  assign sel_tr   = sel_bid_i || sel_ask_i;

  // scan stage: earlier cells win ties of price and age, as in the slot order
  always_comb begin
    bid_win_o = 1'b0;
    ask_win_o = 1'b0;
    if (valid_q && side_q == lobm_pkg::SIDE_BUY) begin
      bid_win_o = !bid_v_i || (price_q > bid_p_i) ||
                  ((price_q == bid_p_i) && (age > bid_age_i));
    end
    if (valid_q && side_q == lobm_pkg::SIDE_SELL) begin
      ask_win_o = !ask_v_i || (price_q < ask_p_i) ||
                  ((price_q == ask_p_i) && (age > ask_age_i));
    end
    bid_v_o   = bid_v_i || bid_win_o;
    bid_p_o   = bid_win_o ? price_q : bid_p_i;
    bid_age_o = bid_win_o ? age : bid_age_i;
    ask_v_o   = ask_v_i || ask_win_o;
    ask_p_o   = ask_win_o ? price_q : ask_p_i;
    ask_age_o = ask_win_o ? age : ask_age_i;
  end

  always_comb begin
    valid_d = valid_q;
    rem_d   = rem_q;
    if (cmd_i.cancel && id_hit_o) begin
      valid_d = 1'b0;
    end
    if (cmd_i.trade && sel_tr) begin
      rem_d = rem_q - trade_qty_i;
      if (rem_d == '0) begin
        valid_d = 1'b0;
      end
    end
    if (cmd_i.write && sel_wr_i) begin
      valid_d = 1'b1;
      rem_d   = new_qty_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    if (cmd_i.write && sel_wr_i) begin
      id_q    <= new_id_i;
      side_q  <= new_side_i;
      price_q <= new_price_i;
      arr_q   <= new_arrival_i;
    end
  end

endmodule

>>> rtl/core/lobm_scan.sv
// lobm_scan: registered winning bid/ask cells, first free slot and full flag
// no dependencies

module lobm_scan #(
  parameter int unsigned Slots = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [Slots-1:0] bid_win_i,
  input  logic [Slots-1:0] ask_win_i,
  input  logic [Slots-1:0] valid_i,
  output logic [Slots-1:0] bid_sel_o,
  output logic [Slots-1:0] ask_sel_o,
  output logic [Slots-1:0] free_sel_o,
  output logic             full_o
);

  logic [Slots-1:0] bid_d, ask_d, free_d;
  logic             bid_found, ask_found, free_found;

  // the last cell that took over the running best holds it
  always_comb begin
    bid_d = '0;
    ask_d = '0;
    free_d = '0;
    bid_found = 1'b0;
    ask_found = 1'b0;
    free_found = 1'b0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!bid_found && bid_win_i[i]) begin
        bid_d[i]  = 1'b1;
        bid_found = 1'b1;
      end
      if (!ask_found && ask_win_i[i]) begin
        ask_d[i]  = 1'b1;
        ask_found = 1'b1;
      end
    end
    for (int i = 0; i < Slots; i++) begin
      if (!free_found && !valid_i[i]) begin
        free_d[i]  = 1'b1;
        free_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bid_sel_o  <= '0;
      ask_sel_o  <= '0;
      free_sel_o <= '0;
      full_o     <= 1'b0;
    end else begin
      bid_sel_o  <= bid_d;
      ask_sel_o  <= ask_d;
      free_sel_o <= free_d;
      full_o     <= !free_found;
    end
  end

endmodule

>>> rtl/core/limit_order_book_matcher.sv
// limit_order_book_matcher: top level, price-time priority order book with matching
// depends on lobm_pkg, lobm_cell, lobm_scan

// The book is a row of ORDER_SLOTS cells. A best bid/ask scan runs through the
// row as a chain that is registered every lobm_pkg::ScanSegCells cells, so it
// settles one chain segment at a time (8 segments at the default size);
// its winners are then registered. Raise start while busy is low to transfer
// one add or cancel. Results come out one per cycle at most, each marked by
// valid_o for a single cycle; the receiver cannot stall, so take every result
// when valid_o is high. last_o marks the final result of an item. Sequence:
// a cancel reports in S_CANCEL, and a zero-quantity or rejected add in
// S_PLACE, then busy drops. A stored add is written in S_PLACE, then S_SCAN
// lets the scan settle and register and S_MATCH reports and applies one
// trade, the two repeating per trade; after the closing result in S_MATCH,
// S_DONE is passed before busy drops. The next transfer can come as soon as
// busy is low.
module limit_order_book_matcher #(
  parameter int unsigned ORDER_SLOTS = 64,
  parameter int unsigned PRICE_BITS  = 16,
  parameter int unsigned QTY_BITS    = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind_i,
  input  logic [lobm_pkg::IdBits-1:0]   order_id_i,
  input  logic                          side_i,
  input  logic [PRICE_BITS-1:0]         price_i,
  input  logic [QTY_BITS-1:0]           quantity_i,
  output logic                          valid_o,
  output logic [lobm_pkg::KindBits-1:0] result_kind_o,
  output logic [lobm_pkg::IdBits-1:0]   buy_id_o,
  output logic [lobm_pkg::IdBits-1:0]   sell_id_o,
  output logic [QTY_BITS-1:0]           trade_qty_o,
  output logic [PRICE_BITS-1:0]         trade_price_o,
  output logic                          last_o
);

  localparam int unsigned AB = lobm_pkg::ArrivalBits;
  localparam int unsigned IB = lobm_pkg::IdBits;
  // number of chain segments
  localparam int unsigned ScanCycles =
    (ORDER_SLOTS + lobm_pkg::ScanSegCells - 1) / lobm_pkg::ScanSegCells;
  localparam int unsigned ScanBits = $clog2(ScanCycles) + 1;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CANCEL = 3'd1;
  localparam logic [2:0] S_PLACE  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_MATCH  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]            state_q, state_d;
  logic [AB-1:0]         counter_q, counter_d;
  logic [ScanBits-1:0]   scan_cnt_q, scan_cnt_d;
  // captured input item
  logic [IB-1:0]         id_q;
  logic                  side_q;
  logic [PRICE_BITS-1:0] price_q;
  logic [QTY_BITS-1:0]   qty_q;

  lobm_pkg::cell_cmd_t   cmd;
  logic [QTY_BITS-1:0]   tqty;

  // scan chain links, one more than cells
  logic [ORDER_SLOTS:0]  bv, av;
  logic [PRICE_BITS-1:0] bp [ORDER_SLOTS+1];
  logic [PRICE_BITS-1:0] ap [ORDER_SLOTS+1];
  logic [AB-1:0]         bage [ORDER_SLOTS+1];
  logic [AB-1:0]         aage [ORDER_SLOTS+1];
  // scan chain outputs of each cell
  logic [ORDER_SLOTS-1:0] bvo, avo;
  logic [PRICE_BITS-1:0]  bpo [ORDER_SLOTS];
  logic [PRICE_BITS-1:0]  apo [ORDER_SLOTS];
  logic [AB-1:0]          bageo [ORDER_SLOTS];
  logic [AB-1:0]          aageo [ORDER_SLOTS];

  logic [ORDER_SLOTS-1:0] bwin, awin, cvalid, chit, bsel, asel, fsel;
  logic                   full;
  logic [IB-1:0]          cid [ORDER_SLOTS];
  logic [PRICE_BITS-1:0]  cprice [ORDER_SLOTS];
  logic [QTY_BITS-1:0]    crem [ORDER_SLOTS];

  // values of the registered winners, through one-hot muxes
  logic [IB-1:0]          bid_id, ask_id;
  logic [PRICE_BITS-1:0]  bid_p, ask_p;
  logic [QTY_BITS-1:0]    bid_rem, ask_rem;
  logic                   have_bid, have_ask;

  assign bv[0]   = 1'b0;
  assign av[0]   = 1'b0;
  assign bp[0]   = '0;
  assign ap[0]   = '0;
  assign bage[0] = '0;
  assign aage[0] = '0;

  for (genvar g = 0; g < ORDER_SLOTS; g++) begin : g_cell
    lobm_cell #(
      .PriceBits(PRICE_BITS),
      .QtyBits  (QTY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .sel_wr_i     (fsel[g]),
      .sel_bid_i    (bsel[g]),
      .sel_ask_i    (asel[g]),
      .new_id_i     (id_q),
      .new_side_i   (side_q),
      .new_price_i  (price_q),
      .new_qty_i    (qty_q),
      .new_arrival_i(counter_q),
      .trade_qty_i  (tqty),
      .counter_i    (counter_q),
      .bid_v_i      (bv[g]),
      .bid_p_i      (bp[g]),
      .bid_age_i    (bage[g]),
      .ask_v_i      (av[g]),
      .ask_p_i      (ap[g]),
      .ask_age_i    (aage[g]),
      .bid_v_o      (bvo[g]),
      .bid_p_o      (bpo[g]),
      .bid_age_o    (bageo[g]),
      .bid_win_o    (bwin[g]),
      .ask_v_o      (avo[g]),
      .ask_p_o      (apo[g]),
      .ask_age_o    (aageo[g]),
      .ask_win_o    (awin[g]),
      .valid_o      (cvalid[g]),
      .id_hit_o     (chit[g]),
      .id_o         (cid[g]),
      .price_o      (cprice[g]),
      .rem_o        (crem[g])
    );

    // register the running best at the end of each segment but the last
    if (((g % lobm_pkg::ScanSegCells) == (lobm_pkg::ScanSegCells - 1)) &&
        (g != ORDER_SLOTS - 1)) begin : g_link_reg
      logic          bv_q, av_q;
      logic [PRICE_BITS-1:0] bp_q, ap_q;
      logic [AB-1:0] bage_q, aage_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          bv_q   <= 1'b0;
          av_q   <= 1'b0;
          bp_q   <= '0;
          ap_q   <= '0;
          bage_q <= '0;
          aage_q <= '0;
        end else begin
          bv_q   <= bvo[g];
          av_q   <= avo[g];
          bp_q   <= bpo[g];
          ap_q   <= apo[g];
          bage_q <= bageo[g];
          aage_q <= aageo[g];
        end
      end

      assign bv[g+1]   = bv_q;
      assign av[g+1]   = av_q;
      assign bp[g+1]   = bp_q;
      assign ap[g+1]   = ap_q;
      assign bage[g+1] = bage_q;
      assign aage[g+1] = aage_q;
    end else begin : g_link
      assign bv[g+1]   = bvo[g];
      assign av[g+1]   = avo[g];
      assign bp[g+1]   = bpo[g];
      assign ap[g+1]   = apo[g];
      assign bage[g+1] = bageo[g];
      assign aage[g+1] = aageo[g];
    end
  end

  lobm_scan #(
    .Slots(ORDER_SLOTS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .bid_win_i (bwin),
    .ask_win_i (awin),
    .valid_i   (cvalid),
    .bid_sel_o (bsel),
    .ask_sel_o (asel),
    .free_sel_o(fsel),
    .full_o    (full)
  );

  always_comb begin
    bid_id = '0; ask_id = '0; bid_p = '0; ask_p = '0; bid_rem = '0; ask_rem = '0;
    for (int i = 0; i < ORDER_SLOTS; i++) begin
      if (bsel[i]) begin
        bid_id  = bid_id | cid[i];
        bid_p   = bid_p | cprice[i];
        bid_rem = bid_rem | crem[i];
      end
      if (asel[i]) begin
        ask_id  = ask_id | cid[i];
        ask_p   = ask_p | cprice[i];
        ask_rem = ask_rem | crem[i];
      end
    end
  end

  assign have_bid = |bsel;
  assign have_ask = |asel;
  assign tqty     = (bid_rem < ask_rem) ? bid_rem : ask_rem;
  assign busy     = (state_q != S_IDLE);

  always_comb begin
    state_d       = state_q;
    counter_d     = counter_q;
    scan_cnt_d    = scan_cnt_q;
    cmd           = '0;
    valid_o       = 1'b0;
    result_kind_o = lobm_pkg::RES_ADD_DONE;
    buy_id_o      = '0;
    sell_id_o     = '0;
    trade_qty_o   = '0;
    trade_price_o = '0;
    last_o        = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          // cancel goes to S_CANCEL; add goes to S_PLACE, which uses the registered free slot pick
          state_d = (kind_i == lobm_pkg::KIND_CANCEL) ? S_CANCEL : S_PLACE;
        end
      end
      S_CANCEL: begin
        cmd.cancel    = 1'b1;
        valid_o       = 1'b1;
        last_o        = 1'b1;
        result_kind_o = (|chit) ? lobm_pkg::RES_CANCELLED : lobm_pkg::RES_NOT_FOUND;
        state_d       = S_IDLE;
      end
      S_PLACE: begin
        if (qty_q == '0) begin
          valid_o = 1'b1;
          last_o  = 1'b1;
          state_d = S_IDLE;
        end else if (full) begin
          valid_o       = 1'b1;
          last_o        = 1'b1;
          result_kind_o = lobm_pkg::RES_ADD_FULL;
          state_d       = S_IDLE;
        end else begin
          cmd.write = 1'b1;
          counter_d = counter_q + 1'b1;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        // scan_cnt counts through the chain segments; the winners register at the end of the last
        if (scan_cnt_q == ScanBits'(ScanCycles - 1)) begin
          scan_cnt_d = '0;
          state_d    = S_MATCH;
        end else begin
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
      end
      S_MATCH: begin
        if (have_bid && have_ask && (bid_p >= ask_p)) begin
          cmd.trade     = 1'b1;
          valid_o       = 1'b1;
          result_kind_o = lobm_pkg::RES_TRADE;
          buy_id_o      = bid_id;
          sell_id_o     = ask_id;
          trade_qty_o   = tqty;
          trade_price_o = ask_p;
          state_d       = S_SCAN;
        end else begin
          valid_o = 1'b1;
          last_o  = 1'b1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      counter_q  <= '0;
      scan_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      counter_q  <= counter_d;
      scan_cnt_q <= scan_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      id_q    <= order_id_i;
      side_q  <= side_i;
      price_q <= price_i;
      qty_q   <= quantity_i;
    end
  end

endmodule

>>> dv/tb_limit_order_book_matcher.sv
// tb_limit_order_book_matcher: self-checking testbench of the order book matcher
// depends on lobm_pkg and limit_order_book_matcher; directed table, full book test, then random phases

`timescale 1ns / 100ps

module tb_limit_order_book_matcher;

  localparam int unsigned Slots     = 64;
  localparam int unsigned PriceBits = 16;
  localparam int unsigned QtyBits   = 24;
  localparam int unsigned IdBits    = lobm_pkg::IdBits;
  localparam int unsigned KindBits  = lobm_pkg::KindBits;
  localparam int unsigned StallMax  = 5000;

  // one add or cancel as the sender drives it
  typedef struct {
    logic                 kind;
    logic [IdBits-1:0]    id;
    logic                 side;
    logic [PriceBits-1:0] price;
    logic [QtyBits-1:0]   qty;
  } order_t;

  // one result as the block reports it
  typedef struct {
    lobm_pkg::res_kind_e  kind;
    logic [IdBits-1:0]    buy_id;
    logic [IdBits-1:0]    sell_id;
    logic [QtyBits-1:0]   qty;
    logic [PriceBits-1:0] price;
    logic                 last;
  } fill_t;

  // directed row; typed rows carry their single closing result kind
  typedef struct {
    order_t              ord;
    bit                  typed;
    lobm_pkg::res_kind_e exp_kind;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 kind_i = lobm_pkg::KIND_ADD;
  logic [IdBits-1:0]    order_id_i = '0;
  logic                 side_i = lobm_pkg::SIDE_BUY;
  logic [PriceBits-1:0] price_i = '0;
  logic [QtyBits-1:0]   quantity_i = '0;
  logic                 valid_o;
  logic [KindBits-1:0]  result_kind_o;
  logic [IdBits-1:0]    buy_id_o;
  logic [IdBits-1:0]    sell_id_o;
  logic [QtyBits-1:0]   trade_qty_o;
  logic [PriceBits-1:0] trade_price_o;
  logic                 last_o;

  limit_order_book_matcher #(
    .ORDER_SLOTS(Slots),
    .PRICE_BITS (PriceBits),
    .QTY_BITS   (QtyBits)
  ) dut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .order_id_i, .side_i, .price_i,
    .quantity_i, .valid_o, .result_kind_o, .buy_id_o, .sell_id_o, .trade_qty_o,
    .trade_price_o, .last_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow book kept by the predictor
  bit                   bk_valid [Slots];
  logic [IdBits-1:0]    bk_id    [Slots];
  logic                 bk_side  [Slots];
  logic [PriceBits-1:0] bk_price [Slots];
  logic [QtyBits-1:0]   bk_left  [Slots];
  logic [31:0]          bk_stamp [Slots];
  logic [31:0]          arrivals = '0;

  fill_t pending_fills[$];
  row_t  typed_rows[$];     // typed expectations, in order of transfer
  int    errors = 0;
  int    stall_cycles = 0;
  int    idle_pct = 0;

  // append one expected result
  function automatic void queue_fill(fill_t f);
    pending_fills = {pending_fills, f};
  endfunction

  // best resting order of one side: best price, then oldest
  function automatic int best_of(logic sd);
    int best;
    logic [31:0] best_age, age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < Slots; i++) begin
      if (!bk_valid[i] || bk_side[i] != sd) continue;
      age = arrivals - bk_stamp[i];
      if (best < 0) begin
        best = i;
        best_age = age;
      end else if (bk_price[i] != bk_price[best]) begin
        if (sd == lobm_pkg::SIDE_BUY ? bk_price[i] > bk_price[best]
                                     : bk_price[i] < bk_price[best]) begin
          best = i;
          best_age = age;
        end
      end else if (age > best_age) begin
        best = i;
        best_age = age;
      end
    end
    return best;
  endfunction

  function automatic fill_t closing(lobm_pkg::res_kind_e k);
    fill_t f;
    f = '{kind: k, buy_id: '0, sell_id: '0, qty: '0, price: '0, last: 1'b1};
    return f;
  endfunction

  // apply one transferred item to the shadow book, queue its results
  function automatic void match_order(order_t o);
    bit found;
    int slot, b, a, n;
    logic [QtyBits-1:0] t;
    fill_t f;
    found = 0;
    slot = -1;
    n = 0;
    if (o.kind == lobm_pkg::KIND_CANCEL) begin
      for (int i = 0; i < Slots; i++)
        if (bk_valid[i] && bk_id[i] == o.id) begin
          bk_valid[i] = 0;
          found = 1;
        end
      queue_fill(closing(found ? lobm_pkg::RES_CANCELLED : lobm_pkg::RES_NOT_FOUND));
      return;
    end
    if (o.qty == '0) begin
      queue_fill(closing(lobm_pkg::RES_ADD_DONE));
      return;
    end
    for (int i = 0; i < Slots; i++)
      if (!bk_valid[i] && slot < 0) slot = i;
    if (slot < 0) begin
      queue_fill(closing(lobm_pkg::RES_ADD_FULL));
      return;
    end
    bk_valid[slot] = 1;
    bk_id[slot]    = o.id;
    bk_side[slot]  = o.side;
    bk_price[slot] = o.price;
    bk_left[slot]  = o.qty;
    bk_stamp[slot] = arrivals;
    arrivals++;
    while (n < Slots - 1) begin
      b = best_of(lobm_pkg::SIDE_BUY);
      a = best_of(lobm_pkg::SIDE_SELL);
      if (b < 0 || a < 0) break;
      if (bk_price[b] < bk_price[a]) break;
      t = bk_left[b] < bk_left[a] ? bk_left[b] : bk_left[a];
      bk_left[b] -= t;
      bk_left[a] -= t;
      f = '{kind: lobm_pkg::RES_TRADE, buy_id: bk_id[b], sell_id: bk_id[a], qty: t,
            price: bk_price[a], last: 1'b0};
      queue_fill(f);
      n++;
      if (bk_left[b] == '0) bk_valid[b] = 0;
      if (bk_left[a] == '0) bk_valid[a] = 0;
    end
    queue_fill(closing(lobm_pkg::RES_ADD_DONE));
  endfunction

  // predict on every transfer; typed rows override the predicted closing kind
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      match_order('{kind: kind_i, id: order_id_i, side: side_i, price: price_i,
                    qty: quantity_i});
      if (typed_rows.size() > 0 && typed_rows[0].ord.id == order_id_i &&
          typed_rows[0].ord.kind == kind_i) begin
        pending_fills[$].kind = typed_rows[0].exp_kind;
        typed_rows.pop_front();
      end
    end
  end

  // results cannot be held off: check each strobe against the oldest expectation
  always @(posedge clk_i) begin
    fill_t e;
    if (rst_ni && valid_o) begin
      if (pending_fills.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch exp no result got k%0d b%h s%h q%0d p%0d l%0d",
                   result_kind_o, buy_id_o, sell_id_o, trade_qty_o, trade_price_o, last_o);
      end else begin
        e = pending_fills.pop_front();
        if (result_kind_o !== e.kind || buy_id_o !== e.buy_id || sell_id_o !== e.sell_id ||
            trade_qty_o !== e.qty || trade_price_o !== e.price || last_o !== e.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp k%0d b%h s%h q%0d p%0d l%0d got k%0d b%h s%h q%0d p%0d l%0d",
                     e.kind, e.buy_id, e.sell_id, e.qty, e.price, e.last, result_kind_o,
                     buy_id_o, sell_id_o, trade_qty_o, trade_price_o, last_o);
        end
      end
    end
  end

  // watchdog on cycles without any transfer or result
  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallMax) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // drive one item and hold it until the block takes it
  task automatic send(order_t o);
    bit taken;
    taken = 0;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start      <= 1'b1;
    kind_i     <= o.kind;
    order_id_i <= o.id;
    side_i     <= o.side;
    price_i    <= o.price;
    quantity_i <= o.qty;
    // busy is settled at the falling edge and holds until the next rising edge
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_fills.size() > 0 || busy) @(posedge clk_i);
  endtask

  // mostly a crowded price band and small ids so orders cross and cancels hit
  function automatic order_t random_order();
    order_t o;
    int r;
    o.kind = ($urandom_range(99) < 25) ? lobm_pkg::KIND_CANCEL : lobm_pkg::KIND_ADD;
    o.id   = ($urandom_range(9) == 0) ? $urandom : $urandom_range(31);
    o.side = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (r < 75) o.price = PriceBits'(1000 + $urandom_range(16) - 8);
    else if (r < 90) o.price = PriceBits'($urandom);
    else o.price = $urandom_range(1) ? '1 : '0;
    r = $urandom_range(99);
    if (r < 80) o.qty = QtyBits'($urandom_range(100, 1));
    else if (r < 85) o.qty = '0;
    else o.qty = QtyBits'($urandom);
    return o;
  endfunction

  row_t rows[19];

  initial begin
    rows = '{
      '{'{lobm_pkg::KIND_CANCEL, 32'd7, lobm_pkg::SIDE_SELL, 16'hffff, 24'hffffff},
        1, lobm_pkg::RES_NOT_FOUND},
      '{'{lobm_pkg::KIND_ADD, 32'd1, lobm_pkg::SIDE_BUY, 16'd100, 24'd0},
        1, lobm_pkg::RES_ADD_DONE},
      '{'{lobm_pkg::KIND_ADD, 32'hffffffff, lobm_pkg::SIDE_BUY, 16'hffff, 24'hffffff},
        1, lobm_pkg::RES_ADD_DONE},
      '{'{lobm_pkg::KIND_ADD, 32'd2, lobm_pkg::SIDE_SELL, 16'd0, 24'd5},
        0, lobm_pkg::RES_TRADE},
      '{'{lobm_pkg::KIND_CANCEL, 32'hffffffff, lobm_pkg::SIDE_BUY, 16'd0, 24'd0},
        1, lobm_pkg::RES_CANCELLED},
      '{'{lobm_pkg::KIND_ADD, 32'd10, lobm_pkg::SIDE_BUY, 16'd50, 24'd10},
        0, lobm_pkg::RES_TRADE},
      '{'{lobm_pkg::KIND_ADD, 32'd11, lobm_pkg::SIDE_BUY, 16'd50, 24'd10},
        0, lobm_pkg::RES_TRADE},
      '{'{lobm_pkg::KIND_ADD, 32'd12, lobm_pkg::SIDE_BUY, 16'd51, 24'd3},
        0, lobm_pkg::RES_TRADE},
      // time priority at 50, price priority of 51
      '{'{lobm_pkg::KIND_ADD, 32'd20, lobm_pkg::SIDE_SELL, 16'd50, 24'd20},
        0, lobm_pkg::RES_TRADE},
      '{'{lobm_pkg::KIND_ADD, 32'd30, lobm_pkg::SIDE_SELL, 16'd60, 24'd4},
        0, lobm_pkg::RES_TRADE},
      '{'{lobm_pkg::KIND_ADD, 32'd30, lobm_pkg::SIDE_SELL, 16'd60, 24'd4},
        0, lobm_pkg::RES_TRADE},
      // duplicate ids go in one cancel
      '{'{lobm_pkg::KIND_CANCEL, 32'd30, lobm_pkg::SIDE_BUY, 16'd0, 24'd0},
        1, lobm_pkg::RES_CANCELLED},
      '{'{lobm_pkg::KIND_CANCEL, 32'd30, lobm_pkg::SIDE_BUY, 16'd0, 24'd0},
        1, lobm_pkg::RES_NOT_FOUND},
      '{'{lobm_pkg::KIND_ADD, 32'd40, lobm_pkg::SIDE_SELL, 16'd70, 24'd5},
        0, lobm_pkg::RES_TRADE},
      '{'{lobm_pkg::KIND_ADD, 32'd41, lobm_pkg::SIDE_SELL, 16'd69, 24'd5},
        0, lobm_pkg::RES_TRADE},
      '{'{lobm_pkg::KIND_ADD, 32'd42, lobm_pkg::SIDE_BUY, 16'hffff, 24'd7},
        0, lobm_pkg::RES_TRADE},
      // filled orders are gone
      '{'{lobm_pkg::KIND_CANCEL, 32'd41, lobm_pkg::SIDE_BUY, 16'd0, 24'd0},
        1, lobm_pkg::RES_NOT_FOUND},
      '{'{lobm_pkg::KIND_CANCEL, 32'd42, lobm_pkg::SIDE_BUY, 16'd0, 24'd0},
        1, lobm_pkg::RES_NOT_FOUND},
      '{'{lobm_pkg::KIND_ADD, 32'h0000ffff, lobm_pkg::SIDE_SELL, 16'h8000, 24'h800000},
        0, lobm_pkg::RES_TRADE}
    };
    for (int i = 0; i < Slots; i++) bk_valid[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, back to back
    foreach (rows[i]) begin
      if (rows[i].typed) typed_rows = {typed_rows, rows[i]};
      send(rows[i].ord);
    end
    drain();

    // fill the book with quiet bids of one id, hit it while full, then clear them at once
    for (int k = 0; k < Slots; k++)
      send('{lobm_pkg::KIND_ADD, 32'd5000, lobm_pkg::SIDE_BUY, 16'd0, 24'd1});
    send('{lobm_pkg::KIND_CANCEL, 32'd5000, lobm_pkg::SIDE_BUY, 16'd0, 24'd0});
    drain();

    // random phases: no idling, mostly idle sender, no idling again, lightly idle sender (receiver cannot stall)
    for (int p = 0; p < 4; p++) begin
      idle_pct = (p == 1) ? 84 : (p == 3) ? 24 : 0;
      repeat (16) send(random_order());
      // pressure: hold off until every expected result is back
      drain();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_fills.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
